>>> design/canopen_drive_response_decoder_top_defines.svh
// Assertion macros for the drive response decoder top level.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef CANOPEN_DRIVE_RESPONSE_DECODER_TOP_DEFINES_SVH
`define CANOPEN_DRIVE_RESPONSE_DECODER_TOP_DEFINES_SVH

// Antecedent holds -> consequent holds in the next cycle.
`define CDRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdrd: next-cycle check failed");

// Antecedent holds -> consequent holds in the same cycle.
`define CDRD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdrd: same-cycle check failed");

`endif

>>> design/cdrd_pkg.sv
// Shared types and constants of the drive response decoder.
// No dependencies.
`default_nettype none

package cdrd_pkg;

  typedef enum logic [1:0] {
    ACT_SDO           = 2'd0,
    ACT_EMERGENCY     = 2'd1,
    ACT_FAILURE_WRITE = 2'd2
  } action_t;

  localparam logic [15:0] OBJ_VELOCITY   = 16'h606C;
  localparam logic [15:0] OBJ_TORQUE     = 16'h6077;
  localparam logic [15:0] OBJ_MOTOR_TEMP = 16'h2025;
  localparam logic [15:0] OBJ_CTRL_TEMP  = 16'h2026;
  localparam logic [15:0] OBJ_WARNING    = 16'h2027;
  localparam logic [15:0] OBJ_ERROR      = 16'h603F;
  localparam logic [15:0] OBJ_STATUS     = 16'h6041;

  localparam logic [7:0] SUB_ZERO = 8'h00;
  localparam logic [7:0] SUB_ONE  = 8'h01;

  localparam logic [2:0] ST_NOT_READY          = 3'd0;
  localparam logic [2:0] ST_SWITCH_ON_DISABLED = 3'd1;
  localparam logic [2:0] ST_READY              = 3'd2;
  localparam logic [2:0] ST_SWITCHED_ON        = 3'd3;
  localparam logic [2:0] ST_ENABLED            = 3'd4;
  localparam logic [2:0] ST_QUICK_STOP         = 3'd5;
  localparam logic [2:0] ST_FAULT_REACTION     = 3'd6;
  localparam logic [2:0] ST_FAULT              = 3'd7;

  localparam logic [7:0] SW_NOT_READY          = 8'h00;
  localparam logic [7:0] SW_SWITCH_ON_DISABLED = 8'h40;
  localparam logic [7:0] SW_READY              = 8'h21;
  localparam logic [7:0] SW_SWITCHED_ON        = 8'h23;
  localparam logic [7:0] SW_ENABLED            = 8'h27;
  localparam logic [7:0] SW_QUICK_STOP         = 8'h07;
  localparam logic [7:0] SW_FAULT_REACTION     = 8'h0F;
  localparam logic [7:0] SW_FAULT              = 8'h08;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] frame_data;
    logic        failure_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] velocity;
    logic signed [15:0] torque;
    logic [7:0]         motor_temp;
    logic [7:0]         ctrl_temp;
    logic [2:0]         drive_state;
    logic               failure;
    logic [15:0]        warning;
    logic [15:0]        error;
    logic [15:0]        emergency;
  } regs_t;

endpackage

`default_nettype wire

>>> design/cdrd_if.sv
// Valid/ready channel interfaces for frame transactions and result transactions.
// No dependencies.
`default_nettype none

interface cdrd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] frame_data;
  logic        failure_value;

  modport source (output valid, action, frame_data, failure_value, input ready);
  modport sink (input valid, action, frame_data, failure_value, output ready);
endinterface

interface cdrd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] actual_velocity;
  logic signed [15:0] actual_torque;
  logic [7:0]         motor_temperature;
  logic [7:0]         controller_temperature;
  logic [2:0]         drive_state;
  logic               critical_failure;
  logic [15:0]        warning_word;
  logic [15:0]        error_code;
  logic [15:0]        emergency_code;

  modport source (
    output valid, actual_velocity, actual_torque, motor_temperature,
           controller_temperature, drive_state, critical_failure,
           warning_word, error_code, emergency_code,
    input ready
  );
  modport sink (
    input valid, actual_velocity, actual_torque, motor_temperature,
          controller_temperature, drive_state, critical_failure,
          warning_word, error_code, emergency_code,
    output ready
  );
endinterface

`default_nettype wire

>>> design/cdrd_in_reg.sv
// Input register stage: captures one frame transaction per cycle while it is empty or advancing.
// Depends on cdrd_pkg and cdrd_in_if.
`default_nettype none

module cdrd_in_reg
  import cdrd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  cdrd_in_if.sink    frame,
  input  wire logic  advance,
  output logic       valid,
  output item_t      item
);

  logic accept;

  assign frame.ready = !valid || advance;
  assign accept      = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.action        <= frame.action;
      item.frame_data    <= frame.frame_data;
      item.failure_value <= frame.failure_value;
    end
  end

endmodule

`default_nettype wire

>>> design/cdrd_decode.sv
// Frame decode: next register bank from the held frame and the current bank.
// Depends on cdrd_pkg.
`default_nettype none

module cdrd_decode
  import cdrd_pkg::*;
(
  input  wire item_t item,
  input  wire regs_t cur,
  output regs_t      nxt
);

  logic [15:0] obj;
  logic [7:0]  sub;
  logic [15:0] word;
  logic [7:0]  sw;

  assign obj  = item.frame_data[23:8];
  assign sub  = item.frame_data[31:24];
  assign word = item.frame_data[47:32];
  assign sw   = item.frame_data[39:32];

  always_comb begin
    nxt = cur;
    case (item.action)
      ACT_SDO: begin
        if (obj == OBJ_VELOCITY) begin
          nxt.velocity = item.frame_data[63:32];
        end else if (obj == OBJ_TORQUE) begin
          nxt.torque = word;
        end else if (obj == OBJ_MOTOR_TEMP) begin
          nxt.motor_temp = sw;
        end else if (obj == OBJ_CTRL_TEMP && sub == SUB_ONE) begin
          nxt.ctrl_temp = sw;
        end else if (obj == OBJ_WARNING && sub == SUB_ZERO) begin
          if (word != 16'd0) begin
            nxt.warning = word;
            nxt.failure = 1'b1;
          end
        end else if (obj == OBJ_ERROR && sub == SUB_ZERO) begin
          if (word != 16'd0) begin
            nxt.error   = word;
            nxt.failure = 1'b1;
          end
        end else if (obj == OBJ_STATUS && sub == SUB_ZERO) begin
          case (sw)
            SW_NOT_READY:          nxt.drive_state = ST_NOT_READY;
            SW_SWITCH_ON_DISABLED: nxt.drive_state = ST_SWITCH_ON_DISABLED;
            SW_READY:              nxt.drive_state = ST_READY;
            SW_SWITCHED_ON:        nxt.drive_state = ST_SWITCHED_ON;
            SW_ENABLED:            nxt.drive_state = ST_ENABLED;
            SW_QUICK_STOP:         nxt.drive_state = ST_QUICK_STOP;
            SW_FAULT_REACTION:     nxt.drive_state = ST_FAULT_REACTION;
            SW_FAULT:              nxt.drive_state = ST_FAULT;
            default:               nxt.drive_state = cur.drive_state;
          endcase
        end
      end
      ACT_EMERGENCY: begin
        nxt.emergency = item.frame_data[15:0];
        nxt.failure   = 1'b1;
      end
      ACT_FAILURE_WRITE: begin
        nxt.failure = item.failure_value;
      end
      default: nxt = cur;
    endcase
  end

endmodule

`default_nettype wire

>>> design/cdrd_result_reg.sv
// Register bank and result stage: the bank is the result payload.
// Depends on cdrd_pkg and cdrd_out_if.
`default_nettype none

module cdrd_result_reg
  import cdrd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  advance,
  input  wire regs_t nxt,
  cdrd_out_if.source result,
  output regs_t      cur
);

  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        cur       <= nxt;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid                  = out_valid;
  assign result.actual_velocity        = cur.velocity;
  assign result.actual_torque          = cur.torque;
  assign result.motor_temperature      = cur.motor_temp;
  assign result.controller_temperature = cur.ctrl_temp;
  assign result.drive_state            = cur.drive_state;
  assign result.critical_failure       = cur.failure;
  assign result.warning_word           = cur.warning;
  assign result.error_code             = cur.error;
  assign result.emergency_code         = cur.emergency;

endmodule

`default_nettype wire

>>> design/canopen_drive_response_decoder_top.sv
// Drive response decoder: decodes SDO responses, emergencies and failure
// writes from a CANopen CiA 402 drive into a bank of status registers. One
// transaction is accepted per clock while the result side does not stall;
// each returns one result transaction holding the whole register bank after
// its update, held in the input register and then the register bank. The rate
// is set by the combinational decode between these two registers.
// Depends on cdrd_pkg, cdrd_if, cdrd_in_reg, cdrd_decode, cdrd_result_reg.
`default_nettype none
`include "canopen_drive_response_decoder_top_defines.svh"

module canopen_drive_response_decoder_top
  import cdrd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  cdrd_in_if.sink    frame,
  cdrd_out_if.source result
);

  logic  s1_valid;
  logic  advance;
  item_t s1_item;
  regs_t cur;
  regs_t nxt;

  assign advance = s1_valid && (!result.valid || result.ready);

  cdrd_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame),
    .advance (advance),
    .valid   (s1_valid),
    .item    (s1_item)
  );

  cdrd_decode u_decode (
    .item (s1_item),
    .cur  (cur),
    .nxt  (nxt)
  );

  cdrd_result_reg u_result_reg (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .nxt     (nxt),
    .result  (result),
    .cur     (cur)
  );

  `CDRD_ASSERT_NEXT(a_accept_fills_stage, frame.valid && frame.ready, s1_valid)
  `CDRD_ASSERT_SAME(a_empty_stage_ready, !s1_valid, frame.ready)
  `CDRD_ASSERT_NEXT(a_emergency_sets_failure,
    advance && s1_item.action == ACT_EMERGENCY,
    result.valid && result.critical_failure)
  `CDRD_ASSERT_NEXT(a_bank_holds, !advance, $stable(cur))

endmodule

`default_nettype wire

>>> tb/tb_canopen_drive_response_decoder_top.sv
`timescale 1ns / 1ps
// Testbench for canopen_drive_response_decoder_top: directed frames, then random frames,
// with random idling on both channels. Results are checked against model or planned banks.
// Depends on cdrd_pkg, cdrd_in_if, cdrd_out_if and the decoder top level.

module tb_canopen_drive_response_decoder_top;
  import cdrd_pkg::*;

  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int RANDOM_FRAMES = 750;

  typedef struct {
    item_t frame;
    bit    typed;
    regs_t want;
    bit    drain;
  } plan_row_t;

  logic clk;
  logic rst;

  cdrd_in_if  frame_bus ();
  cdrd_out_if result_bus ();

  canopen_drive_response_decoder_top DUT (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_bus),
    .result (result_bus)
  );

  regs_t     drive_bank;
  regs_t     expected_banks[$];
  plan_row_t frame_plan[$];
  int        mismatch_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // register bank update for one accepted frame transaction
  function automatic regs_t decode_frame(input item_t f);
    logic [15:0] obj;
    logic [7:0]  sub;
    logic [15:0] word;
    obj  = f.frame_data[23:8];
    sub  = f.frame_data[31:24];
    word = f.frame_data[47:32];
    case (f.action)
      ACT_SDO: begin
        if (obj == OBJ_VELOCITY) begin
          drive_bank.velocity = f.frame_data[63:32];
        end else if (obj == OBJ_TORQUE) begin
          drive_bank.torque = word;
        end else if (obj == OBJ_MOTOR_TEMP) begin
          drive_bank.motor_temp = word[7:0];
        end else if (obj == OBJ_CTRL_TEMP && sub == SUB_ONE) begin
          drive_bank.ctrl_temp = word[7:0];
        end else if (obj == OBJ_WARNING && sub == SUB_ZERO) begin
          if (word != '0) begin
            drive_bank.warning = word;
            drive_bank.failure = 1'b1;
          end
        end else if (obj == OBJ_ERROR && sub == SUB_ZERO) begin
          if (word != '0) begin
            drive_bank.error   = word;
            drive_bank.failure = 1'b1;
          end
        end else if (obj == OBJ_STATUS && sub == SUB_ZERO) begin
          case (word[7:0])
            SW_NOT_READY:          drive_bank.drive_state = ST_NOT_READY;
            SW_SWITCH_ON_DISABLED: drive_bank.drive_state = ST_SWITCH_ON_DISABLED;
            SW_READY:              drive_bank.drive_state = ST_READY;
            SW_SWITCHED_ON:        drive_bank.drive_state = ST_SWITCHED_ON;
            SW_ENABLED:            drive_bank.drive_state = ST_ENABLED;
            SW_QUICK_STOP:         drive_bank.drive_state = ST_QUICK_STOP;
            SW_FAULT_REACTION:     drive_bank.drive_state = ST_FAULT_REACTION;
            SW_FAULT:              drive_bank.drive_state = ST_FAULT;
            default: ;
          endcase
        end
      end
      ACT_EMERGENCY: begin
        drive_bank.emergency = f.frame_data[15:0];
        drive_bank.failure   = 1'b1;
      end
      ACT_FAILURE_WRITE: drive_bank.failure = f.failure_value;
      default: ;
    endcase
    return drive_bank;
  endfunction

  function automatic void plan(input item_t f, input bit typed = 1'b0,
                               input regs_t want = '0, input bit drain = 1'b0);
    plan_row_t row;
    row.frame = f;
    row.typed = typed;
    row.want  = want;
    row.drain = drain;
    frame_plan.push_back(row);
  endfunction

  function automatic void plan_sdo(input logic [15:0] obj, input logic [7:0] sub,
                                   input logic [31:0] val);
    plan(item_t'{ACT_SDO, {val, sub, obj, 8'h43}, 1'b0});
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return '1;
      4: return 32'h0000_8000;
      5: return 32'h0000_7FFF;
      6: return 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t random_frame();
    item_t       f;
    logic [15:0] obj;
    logic [7:0]  sub;
    logic [31:0] val;
    int          pick;
    f.action        = ACT_SDO;
    f.frame_data    = {$urandom, $urandom};
    f.failure_value = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(0, 6))
        0: obj = OBJ_VELOCITY;
        1: obj = OBJ_TORQUE;
        2: obj = OBJ_MOTOR_TEMP;
        3: obj = OBJ_CTRL_TEMP;
        4: obj = OBJ_WARNING;
        5: obj = OBJ_ERROR;
        default: obj = OBJ_STATUS;
      endcase
      sub = 8'($urandom);
      if ($urandom_range(0, 6) != 0) sub = (obj == OBJ_CTRL_TEMP) ? SUB_ONE : SUB_ZERO;
      val = any_word();
      if (obj == OBJ_STATUS && $urandom_range(0, 5) != 0) begin
        case ($urandom_range(0, 7))
          0: val[7:0] = SW_NOT_READY;
          1: val[7:0] = SW_SWITCH_ON_DISABLED;
          2: val[7:0] = SW_READY;
          3: val[7:0] = SW_SWITCHED_ON;
          4: val[7:0] = SW_ENABLED;
          5: val[7:0] = SW_QUICK_STOP;
          6: val[7:0] = SW_FAULT_REACTION;
          default: val[7:0] = SW_FAULT;
        endcase
      end
      f.frame_data[63:8] = {val, sub, obj};
    end else if (pick < 80) begin
      f.action = ACT_EMERGENCY;
      if ($urandom_range(0, 7) == 0) f.frame_data[15:0] = '0;
    end else if (pick < 88) begin
      f.action = ACT_FAILURE_WRITE;
    end else if (pick < 92) begin
      f.action = ACT_RESERVED;
    end
    return f;
  endfunction

  // idle cycles before the next transaction, with occasional back-to-back stretches
  function automatic int next_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic check_bank(input regs_t got);
    regs_t want;
    if (expected_banks.size() == 0) begin
      report_mismatch("result with nothing pending", 64'(got.emergency), '0);
      return;
    end
    want = expected_banks.pop_front();
    if (got.velocity !== want.velocity)
      report_mismatch("actual_velocity", 64'($unsigned(got.velocity)),
                      64'($unsigned(want.velocity)));
    if (got.torque !== want.torque)
      report_mismatch("actual_torque", 64'($unsigned(got.torque)),
                      64'($unsigned(want.torque)));
    if (got.motor_temp !== want.motor_temp)
      report_mismatch("motor_temperature", 64'(got.motor_temp), 64'(want.motor_temp));
    if (got.ctrl_temp !== want.ctrl_temp)
      report_mismatch("controller_temperature", 64'(got.ctrl_temp), 64'(want.ctrl_temp));
    if (got.drive_state !== want.drive_state)
      report_mismatch("drive_state", 64'(got.drive_state), 64'(want.drive_state));
    if (got.failure !== want.failure)
      report_mismatch("critical_failure", 64'(got.failure), 64'(want.failure));
    if (got.warning !== want.warning)
      report_mismatch("warning_word", 64'(got.warning), 64'(want.warning));
    if (got.error !== want.error)
      report_mismatch("error_code", 64'(got.error), 64'(want.error));
    if (got.emergency !== want.emergency)
      report_mismatch("emergency_code", 64'(got.emergency), 64'(want.emergency));
  endtask

  initial begin : stimulus
    plan_row_t row;
    int        gap;
    int        calm;
    calm           = 0;
    mismatch_count = 0;
    drive_bank     = '0;
    rst                     <= 1'b1;
    frame_bus.valid         <= 1'b0;
    frame_bus.action        <= ACT_SDO;
    frame_bus.frame_data    <= '0;
    frame_bus.failure_value <= 1'b0;

    plan(item_t'{ACT_RESERVED, '1, 1'b1}, 1'b1, '0);
    plan(item_t'{ACT_EMERGENCY, '0, 1'b0}, 1'b1, regs_t'{failure: 1'b1, default: '0});
    plan(item_t'{ACT_FAILURE_WRITE, '0, 1'b0}, 1'b1, '0);
    plan(item_t'{ACT_EMERGENCY, '1, 1'b1}, 1'b1,
         regs_t'{emergency: 16'hFFFF, failure: 1'b1, default: '0});
    plan(item_t'{ACT_FAILURE_WRITE, '1, 1'b0}, 1'b1, regs_t'{emergency: 16'hFFFF, default: '0});
    plan(item_t'{ACT_SDO, {32'h8000_0000, SUB_ZERO, OBJ_VELOCITY, 8'h43}, 1'b0}, 1'b1,
         regs_t'{velocity: 32'h8000_0000, emergency: 16'hFFFF, default: '0});
    plan_sdo(OBJ_VELOCITY, 8'hFF, 32'h7FFF_FFFF);
    plan_sdo(OBJ_TORQUE, SUB_ZERO, 32'hFFFF_8000);
    plan_sdo(OBJ_MOTOR_TEMP, 8'hA5, 32'h0000_00FF);
    plan_sdo(OBJ_CTRL_TEMP, SUB_ONE, 32'hFFFF_FFFF);
    plan_sdo(OBJ_WARNING, SUB_ZERO, 32'hFFFF_0000);
    plan_sdo(OBJ_WARNING, SUB_ZERO, 32'h0000_FFFF);
    plan_sdo(OBJ_ERROR, SUB_ZERO, 32'h0000_0000);
    plan_sdo(OBJ_ERROR, SUB_ZERO, 32'h0000_8001);
    plan_sdo(OBJ_ERROR, SUB_ONE, 32'h0000_1234);
    plan_sdo(OBJ_STATUS, SUB_ZERO, {24'h0, SW_SWITCH_ON_DISABLED});
    plan_sdo(OBJ_STATUS, SUB_ZERO, {24'h0, SW_READY});
    plan_sdo(OBJ_STATUS, SUB_ZERO, {24'h0, SW_SWITCHED_ON});
    plan_sdo(OBJ_STATUS, SUB_ZERO, {24'h0, SW_ENABLED});
    plan_sdo(OBJ_STATUS, SUB_ZERO, {24'h0, SW_QUICK_STOP});
    plan_sdo(OBJ_STATUS, SUB_ZERO, {24'h0, SW_FAULT_REACTION});
    plan_sdo(OBJ_STATUS, SUB_ZERO, {24'h0, SW_FAULT});
    plan_sdo(OBJ_STATUS, SUB_ZERO, {24'h0, SW_NOT_READY});
    plan_sdo(OBJ_STATUS, SUB_ZERO, 32'h0000_0037);
    plan_sdo(16'h6C60, SUB_ZERO, 32'h1234_5678);

    for (int n = 0; n < RANDOM_FRAMES; n++)
      plan(random_frame(), 1'b0, '0, n == 0 || n == RANDOM_FRAMES / 2);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (frame_plan.size() != 0) begin
      row = frame_plan.pop_front();
      gap = next_gap(calm);
      if (gap != 0 || (row.drain && expected_banks.size() != 0)) begin
        frame_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (row.drain)
          while (expected_banks.size() != 0) @(posedge clk);
      end
      frame_bus.valid         <= 1'b1;
      frame_bus.action        <= row.frame.action;
      frame_bus.frame_data    <= row.frame.frame_data;
      frame_bus.failure_value <= row.frame.failure_value;
      do @(posedge clk); while (!frame_bus.ready);
      if (row.typed) begin
        void'(decode_frame(row.frame));
        expected_banks.push_back(row.want);
      end else begin
        expected_banks.push_back(decode_frame(row.frame));
      end
    end
    frame_bus.valid <= 1'b0;

    while (expected_banks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : result_sink
    regs_t got;
    int    gap;
    int    calm;
    calm = 0;
    result_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = next_gap(calm);
      if (gap != 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      got.velocity    = result_bus.actual_velocity;
      got.torque      = result_bus.actual_torque;
      got.motor_temp  = result_bus.motor_temperature;
      got.ctrl_temp   = result_bus.controller_temperature;
      got.drive_state = result_bus.drive_state;
      got.failure     = result_bus.critical_failure;
      got.warning     = result_bus.warning_word;
      got.error       = result_bus.error_code;
      got.emergency   = result_bus.emergency_code;
      check_bank(got);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> canopen_drive_response_decoder_top.f
+incdir+design
design/cdrd_pkg.sv
design/cdrd_if.sv
design/cdrd_in_reg.sv
design/cdrd_decode.sv
design/cdrd_result_reg.sv
design/canopen_drive_response_decoder_top.sv
tb/tb_canopen_drive_response_decoder_top.sv
